// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge, off while in reset
`define AST_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication in the same cycle
`define AST_IMPL(lbl, ante, cons, msg) \
  `AST_CLK(lbl, (ante) |-> (cons), msg)

// Implication in the next cycle
`define AST_NEXT(lbl, ante, cons, msg) \
  `AST_CLK(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/i2cbm_pkg.sv =====
// Shared types and constants for the I2C byte master.
// No dependencies; used by the engine and the top level.
package i2cbm_pkg;

  localparam logic [1:0]  OP_TICK  = 2'd0;
  localparam logic [1:0]  OP_WRITE = 2'd1;
  localparam logic [1:0]  OP_READ  = 2'd2;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd100;
  localparam int          DATA_BITS         = 8;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_S0,
    PH_S1,
    PH_S2,
    PH_WL,
    PH_WH,
    PH_RL,
    PH_RH,
    PH_P0,
    PH_P1,
    PH_P2,
    PH_P3
  } phase_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] tx_byte;
    logic       with_start;
    logic       with_stop;
    logic       send_ack;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       acked;
    logic       rejected;
  } res_t;

endpackage

// ===== rtl/i2cbm_engine.sv =====
// Bus phase engine: holds the sequence state and works out one result per request.
// Depends on i2cbm_pkg.
module i2cbm_engine import i2cbm_pkg::*; #(
  parameter int TICK_COUNTER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        req_valid,
  input  req_t        req,
  input  logic [15:0] half_period,
  output res_t        res
);

  localparam int TCB = TICK_COUNTER_BITS;
  localparam int CW  = (TCB >= 16) ? TCB + 1 : 17;

  phase_t          phase_r,    phase_nxt;
  logic [3:0]      bit_r,      bit_nxt;
  logic [7:0]      shift_r,    shift_nxt;
  logic [TCB-1:0]  tick_r,     tick_nxt;
  logic            stop_r,     stop_nxt;
  logic            ackf_r,     ackf_nxt;
  logic            read_r,     read_nxt;
  logic            scl_r,      scl_nxt;
  logic            sda_r,      sda_nxt;
  logic            acks_r,     acks_nxt;
  logic [7:0]      rx_r,       rx_nxt;
  logic            done;
  logic            rej;

  logic            busy;
  logic            is_cmd;
  logic            phase_end;
  logic [CW-1:0]   tick_inc;
  logic [7:0]      sh;
  logic [3:0]      bi;

  assign busy      = (phase_r != PH_IDLE);
  assign is_cmd    = (req.operation == OP_WRITE) || (req.operation == OP_READ);
  assign tick_inc  = CW'(tick_r) + CW'(1);
  assign phase_end = (tick_inc >= CW'(half_period)) || (&tick_r);

  // Shifted data and bit count as they stand after a high phase
  always_comb begin
    sh = shift_r;
    if (bit_r < 4'd8) begin
      if (phase_r == PH_RH) begin
        sh = {shift_r[6:0], req.sda_in};
      end else begin
        sh = {shift_r[6:0], 1'b0};
      end
    end
    bi = bit_r + 4'd1;
  end

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    tick_nxt  = tick_r;
    stop_nxt  = stop_r;
    ackf_nxt  = ackf_r;
    read_nxt  = read_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    acks_nxt  = acks_r;
    rx_nxt    = rx_r;
    done      = 1'b0;
    rej       = 1'b0;
    if (req_valid) begin
      if (is_cmd) begin
        if (busy) begin
          rej = 1'b1;
        end else begin
          bit_nxt  = '0;
          tick_nxt = '0;
          stop_nxt = req.with_stop;
          read_nxt = (req.operation == OP_READ);
          ackf_nxt = (req.operation == OP_READ) && req.send_ack;
          if (req.operation == OP_READ) begin
            shift_nxt = '0;
            phase_nxt = PH_RL;
            sda_nxt   = 1'b1;
          end else begin
            shift_nxt = req.tx_byte;
            if (req.with_start) begin
              phase_nxt = PH_S0;
              scl_nxt   = 1'b1;
              sda_nxt   = 1'b1;
            end else begin
              phase_nxt = PH_WL;
              sda_nxt   = req.tx_byte[DATA_BITS-1];
            end
          end
        end
      end else if (busy) begin
        if (phase_end) begin
          tick_nxt = '0;
          case (phase_r)
            PH_S0: begin
              phase_nxt = PH_S1;
              sda_nxt   = 1'b0;
            end
            PH_S1: begin
              phase_nxt = PH_S2;
              scl_nxt   = 1'b0;
            end
            PH_S2: begin
              phase_nxt = PH_WL;
              sda_nxt   = (bit_r >= 4'd8) ? ~ackf_r : shift_r[DATA_BITS-1];
            end
            PH_WL: begin
              phase_nxt = PH_WH;
              scl_nxt   = 1'b1;
            end
            PH_RL: begin
              phase_nxt = PH_RH;
              scl_nxt   = 1'b1;
            end
            PH_WH, PH_RH: begin
              if (phase_r == PH_RH && bit_r >= 4'd8) begin
                acks_nxt = ~req.sda_in;
              end
              shift_nxt = sh;
              bit_nxt   = bi;
              scl_nxt   = 1'b0;
              if (bi < 4'd8) begin
                // next data bit
                phase_nxt = read_r ? PH_RL : PH_WL;
                sda_nxt   = read_r ? 1'b1 : sh[DATA_BITS-1];
              end else if (bi == 4'd8) begin
                // acknowledge bit: master drives it on a read, slave on a write
                phase_nxt = read_r ? PH_WL : PH_RL;
                sda_nxt   = read_r ? ~ackf_r : 1'b1;
              end else if (stop_r) begin
                phase_nxt = PH_P0;
              end else begin
                if (read_r) begin
                  rx_nxt = sh;
                end
                phase_nxt = PH_IDLE;
                done      = 1'b1;
              end
            end
            PH_P0: begin
              phase_nxt = PH_P1;
              sda_nxt   = 1'b0;
            end
            PH_P1: begin
              phase_nxt = PH_P2;
              scl_nxt   = 1'b1;
            end
            PH_P2: begin
              phase_nxt = PH_P3;
              sda_nxt   = 1'b1;
            end
            PH_P3: begin
              if (read_r) begin
                rx_nxt = shift_r;
              end
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end else begin
          tick_nxt = tick_inc[TCB-1:0];
        end
      end
    end
  end

  // Result for this request
  always_comb begin
    res.scl_out  = scl_nxt;
    res.sda_out  = sda_nxt;
    res.busy_res = (phase_nxt != PH_IDLE);
    res.done_res = done;
    res.rx_byte  = rx_nxt;
    res.acked    = acks_nxt;
    res.rejected = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bit_r   <= '0;
      shift_r <= '0;
      tick_r  <= '0;
      stop_r  <= 1'b0;
      ackf_r  <= 1'b0;
      read_r  <= 1'b0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      acks_r  <= 1'b0;
      rx_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      tick_r  <= tick_nxt;
      stop_r  <= stop_nxt;
      ackf_r  <= ackf_nxt;
      read_r  <= read_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      acks_r  <= acks_nxt;
      rx_r    <= rx_nxt;
    end
  end

endmodule

// ===== rtl/i2c_byte_master_core.sv =====
// Top level of the I2C byte master: request channel, result channel with skid stage,
// half period register. Depends on i2cbm_pkg and i2cbm_engine.
//
//   channel  direction  handshake        payload
//   in_      request    in_valid/stall   operation, tx_byte, flags, sda_in
//   out_     result     out_valid/stall  scl, sda, busy, done, rx_byte, acked, rejected
//   cfg_     write      cfg_valid/ready  half_period_ticks
//
// One request per clock unless in_stall; its result is registered in out_ or the skid.
// The engine state updates in the same cycle that the request is taken.
// A two-deep result buffer (output register plus skid) lets in_stall come from a flop.
// Reset is synchronous: bus released high, engine idle, half period 100 ticks.
// No clearing pass after reset: requests are taken from the first cycle.
module i2c_byte_master_core import i2cbm_pkg::*; #(
  parameter int TICK_COUNTER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_tx_byte,
  input  logic        in_with_start,
  input  logic        in_with_stop,
  input  logic        in_send_ack,
  input  logic        in_sda_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl_out,
  output logic        out_sda_out,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [7:0]  out_rx_byte,
  output logic        out_acked,
  output logic        out_rejected,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_half_period_ticks
);

  logic [15:0] half_r;
  req_t        req;
  res_t        res;
  res_t        out_r,  out_nxt;
  res_t        skid_r, skid_nxt;
  logic        out_valid_r,  out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  logic        in_acc;
  logic        out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !skid_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    req.operation  = in_operation;
    req.tx_byte    = in_tx_byte;
    req.with_start = in_with_start;
    req.with_stop  = in_with_stop;
    req.send_ack   = in_send_ack;
    req.sda_in     = in_sda_in;
  end

  i2cbm_engine #(
    .TICK_COUNTER_BITS(TICK_COUNTER_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_acc),
    .req        (req),
    .half_period(half_r),
    .res        (res)
  );

  // Output register and skid stage
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_free) begin
      // drain the skid first; a new request is held off while it is full
      out_nxt        = skid_valid_r ? skid_r : res;
      out_valid_nxt  = skid_valid_r || in_acc;
      skid_valid_nxt = 1'b0;
    end else if (in_acc) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
      half_r       <= HALF_PERIOD_RESET;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        half_r <= cfg_half_period_ticks;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_scl_out  = out_r.scl_out;
  assign out_sda_out  = out_r.sda_out;
  assign out_busy_res = out_r.busy_res;
  assign out_done_res = out_r.done_res;
  assign out_rx_byte  = out_r.rx_byte;
  assign out_acked    = out_r.acked;
  assign out_rejected = out_r.rejected;

endmodule

// ===== rtl/i2cbm_checker.sv =====
// Port-level checks for the I2C byte master, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module i2cbm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_operation,
  input logic [7:0]  in_tx_byte,
  input logic        in_with_start,
  input logic        in_with_stop,
  input logic        in_send_ack,
  input logic        in_sda_in,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_scl_out,
  input logic        out_sda_out,
  input logic        out_busy_res,
  input logic        out_done_res,
  input logic [7:0]  out_rx_byte,
  input logic        out_acked,
  input logic        out_rejected,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [15:0] cfg_half_period_ticks
);

  // hold a stalled result
  `AST_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_rx_byte) && $stable(out_done_res), "stalled result changed")

  // a finished sequence leaves the engine idle
  `AST_IMPL(a_done_idle, out_valid && out_done_res, !out_busy_res, "done while still busy")

  // a refused command only happens mid-sequence
  `AST_IMPL(a_rej_busy, out_valid && out_rejected, out_busy_res && !out_done_res, "rejected while idle")

  // skid stage only fills behind a waiting result
  `AST_IMPL(a_stall_empty, !out_valid, !in_stall, "input stalled with empty output")

endmodule

bind i2c_byte_master_core i2cbm_checker u_i2cbm_checker (.*);

// ===== test/i2c_byte_master_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for i2c_byte_master_core: byte writes and reads driven by tick requests.
// Holds its own model of the bus phases; depends on i2cbm_pkg and the core RTL.
module i2c_byte_master_core_tb;
  import i2cbm_pkg::*;

  localparam logic [1:0] OP_SPARE       = 2'd3;  // decodes as a tick
  localparam int         SEQ_PHASES     = 25;    // start, nine bits, stop
  localparam int         HOLD_CYCLES    = 300;
  localparam int         WATCHDOG_LIMIT = 3000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = OP_TICK;
  logic [7:0]  in_tx_byte = '0;
  logic        in_with_start = 1'b0;
  logic        in_with_stop = 1'b0;
  logic        in_send_ack = 1'b0;
  logic        in_sda_in = 1'b1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_scl_out;
  logic        out_sda_out;
  logic        out_busy_res;
  logic        out_done_res;
  logic [7:0]  out_rx_byte;
  logic        out_acked;
  logic        out_rejected;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_half_period_ticks = '0;

  // bus model
  phase_t      bus_ph = PH_IDLE;
  logic [3:0]  bit_cnt = '0;
  logic [7:0]  shreg = '0;
  logic [15:0] tick_cnt = '0;
  logic        pend_stop = 1'b0;
  logic        pend_ack = 1'b0;
  logic        pend_read = 1'b0;
  logic        scl_lvl = 1'b1;
  logic        sda_lvl = 1'b1;
  logic        ack_bit = 1'b0;
  logic [7:0]  rx_keep = '0;
  logic [15:0] half_ticks = HALF_PERIOD_RESET;

  req_t        req_feed[$];
  res_t        status_due[$];
  req_t        offered;
  res_t        want;
  int          queued_n = 0;
  int          writes_done = 0;
  int          reads_done = 0;
  int          rejects = 0;
  int          errors = 0;
  int          in_idle = 12;
  int          out_idle = 12;
  int          hold_ask = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          quiet = 0;

  i2c_byte_master_core dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_operation          (in_operation),
    .in_tx_byte            (in_tx_byte),
    .in_with_start         (in_with_start),
    .in_with_stop          (in_with_stop),
    .in_send_ack           (in_send_ack),
    .in_sda_in             (in_sda_in),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_scl_out           (out_scl_out),
    .out_sda_out           (out_sda_out),
    .out_busy_res          (out_busy_res),
    .out_done_res          (out_done_res),
    .out_rx_byte           (out_rx_byte),
    .out_acked             (out_acked),
    .out_rejected          (out_rejected),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_half_period_ticks (cfg_half_period_ticks)
  );

  always #5 clk = ~clk;

  function automatic void enter_phase(input phase_t p);
    bus_ph = p;
    tick_cnt = '0;
    case (p)
      PH_S0: begin
        scl_lvl = 1'b1;
        sda_lvl = 1'b1;
      end
      PH_S1, PH_P1: sda_lvl = 1'b0;
      PH_S2: scl_lvl = 1'b0;
      // past the eighth bit this is the master's ACK or NACK
      PH_WL: sda_lvl = (bit_cnt >= 4'd8) ? !pend_ack : shreg[7];
      PH_RL, PH_P3: sda_lvl = 1'b1;
      PH_WH, PH_RH, PH_P2: scl_lvl = 1'b1;
      default: ;
    endcase
  endfunction

  function automatic void finish_seq();
    bus_ph = PH_IDLE;
    tick_cnt = '0;
    if (pend_read) begin
      rx_keep = shreg;
      reads_done++;
    end else begin
      writes_done++;
    end
  endfunction

  function automatic logic next_bit();
    scl_lvl = 1'b0;
    bit_cnt = bit_cnt + 4'd1;
    if (bit_cnt < 4'd8) begin
      enter_phase(pend_read ? PH_RL : PH_WL);
    end else if (bit_cnt == 4'd8) begin
      // acknowledge slot: the reader drives, the writer listens
      enter_phase(pend_read ? PH_WL : PH_RL);
    end else if (pend_stop) begin
      enter_phase(PH_P0);
    end else begin
      finish_seq();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic end_phase(input logic sda);
    case (bus_ph)
      PH_S0: enter_phase(PH_S1);
      PH_S1: enter_phase(PH_S2);
      PH_S2: enter_phase(PH_WL);
      PH_WL: enter_phase(PH_WH);
      PH_RL: enter_phase(PH_RH);
      PH_P0: enter_phase(PH_P1);
      PH_P1: enter_phase(PH_P2);
      PH_P2: enter_phase(PH_P3);
      PH_WH: begin
        if (bit_cnt < 4'd8) shreg = shreg << 1;
        return next_bit();
      end
      PH_RH: begin
        if (bit_cnt < 4'd8) shreg = {shreg[6:0], sda};
        else ack_bit = !sda;
        return next_bit();
      end
      PH_P3: begin
        finish_seq();
        return 1'b1;
      end
      default: begin
        bus_ph = PH_IDLE;
        tick_cnt = '0;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic res_t advance_bus(input req_t r);
    res_t        e;
    logic        busy_now;
    logic        done;
    logic        rej;
    logic [16:0] nxt;
    busy_now = (bus_ph != PH_IDLE);
    done = 1'b0;
    rej = 1'b0;
    if (r.operation == OP_WRITE || r.operation == OP_READ) begin
      if (busy_now) begin
        rej = 1'b1;
        rejects++;
      end else begin
        bit_cnt = '0;
        pend_stop = r.with_stop;
        pend_read = (r.operation == OP_READ);
        pend_ack = pend_read && r.send_ack;
        if (pend_read) begin
          shreg = '0;
          enter_phase(PH_RL);
        end else begin
          shreg = r.tx_byte;
          enter_phase(r.with_start ? PH_S0 : PH_WL);
        end
      end
    end else if (busy_now) begin
      nxt = {1'b0, tick_cnt} + 17'd1;
      if (nxt >= {1'b0, half_ticks} || (&tick_cnt)) done = end_phase(r.sda_in);
      else tick_cnt = nxt[15:0];
    end
    e.scl_out  = scl_lvl;
    e.sda_out  = sda_lvl;
    e.busy_res = (bus_ph != PH_IDLE);
    e.done_res = done;
    e.rx_byte  = rx_keep;
    e.acked    = ack_bit;
    e.rejected = rej;
    return e;
  endfunction

  function automatic void push_req(input logic [1:0] op, input logic [7:0] tx,
                                   input logic st, input logic sp, input logic ak,
                                   input logic sda);
    req_t r;
    r.operation  = op;
    r.tx_byte    = tx;
    r.with_start = st;
    r.with_stop  = sp;
    r.send_ack   = ak;
    r.sda_in     = sda;
    req_feed.push_back(r);
    queued_n++;
  endfunction

  function automatic void push_cmd();
    push_req($urandom_range(1) ? OP_READ : OP_WRITE, 8'($urandom_range(255)),
             1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
             1'($urandom_range(1)));
  endfunction

  // one command followed by enough ticks to finish it, now and then cut short or capped at tick_cap
  function automatic void queue_transfer(input int tick_cap);
    int per_phase;
    int need;
    per_phase = (half_ticks == 0) ? 1 : int'(half_ticks);
    need = SEQ_PHASES * per_phase + $urandom_range(2);
    if ($urandom_range(9) == 0) need = $urandom_range(need);
    if (need > tick_cap) need = tick_cap;
    push_cmd();
    repeat (need) begin
      if ($urandom_range(31) == 0) push_cmd();
      else push_req(($urandom_range(15) == 0) ? OP_SPARE : OP_TICK,
                    8'($urandom_range(255)), 1'($urandom_range(1)),
                    1'($urandom_range(1)), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
    end
  endfunction

  task automatic write_half(input logic [15:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_half_period_ticks <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    half_ticks = v;
  endtask

  task automatic drain();
    do @(negedge clk); while (req_feed.size() != 0 || in_valid || status_due.size() != 0);
  endtask

  task automatic run_phase(input logic [15:0] h, input int target, input int pct,
                           input int tick_cap);
    int goal;
    write_half(h);
    in_idle = pct;
    out_idle = pct;
    goal = queued_n + target;
    while (queued_n < goal) queue_transfer(tick_cap);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      errors++;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) status_due.push_back(advance_bus(offered));
      if (!in_valid || !in_stall) begin
        if (req_feed.size() != 0 && $urandom_range(99) >= in_idle) begin
          offered = req_feed.pop_front();
          in_valid <= 1'b1;
          in_operation <= offered.operation;
          in_tx_byte <= offered.tx_byte;
          in_with_start <= offered.with_start;
          in_with_stop <= offered.with_stop;
          in_send_ack <= offered.send_ack;
          in_sda_in <= offered.sda_in;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (status_due.size() == 0) begin
          $error("result arrived with no request outstanding");
          errors++;
        end else begin
          want = status_due.pop_front();
          check_field("scl_out", 8'(want.scl_out), 8'(out_scl_out));
          check_field("sda_out", 8'(want.sda_out), 8'(out_sda_out));
          check_field("busy_res", 8'(want.busy_res), 8'(out_busy_res));
          check_field("done_res", 8'(want.done_res), 8'(out_done_res));
          check_field("rx_byte", want.rx_byte, out_rx_byte);
          check_field("acked", 8'(want.acked), 8'(out_acked));
          check_field("rejected", 8'(want.rejected), 8'(out_rejected));
        end
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_seen != hold_ask) begin
        // long hold-off: let the core back up into its input
        hold_seen = hold_ask;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < out_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // one tick per phase; idle ticks, a write with no leading start, a read
    // asking for a start (ignored), NACK and stop, and commands while busy
    write_half(16'd0);
    push_req(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    push_req(OP_SPARE, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1);
    push_req(OP_WRITE, 8'h80, 1'b0, 1'b0, 1'b0, 1'b0);
    for (int i = 0; i < 18; i++) begin
      if (i == 5) push_req(OP_READ, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1);
      push_req(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    end
    push_req(OP_READ, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0);
    for (int i = 0; i < 22; i++) begin
      if (i == 9) push_req(OP_WRITE, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1);
      push_req(OP_TICK, 8'hFF, 1'b1, 1'b1, 1'b1, i[0]);
    end
    drain();

    run_phase(16'd1, 180, 12, 1000);
    drain();
    run_phase(16'd2, 180, 12, 1000);
    hold_ask++;
    drain();
    // widest half period: only part of a sequence fits
    run_phase(16'hFFFF, 150, 12, 200);
    drain();
    run_phase(16'd3, 180, 0, 1000);
    drain();
    run_phase(16'd0, 180, 12, 1000);
    drain();
    run_phase(16'd1, 180, 12, 1000);
    drain();

    repeat (8) @(posedge clk);
    $display("Ran %0d requests: %0d writes and %0d reads completed, %0d commands refused.",
             queued_n, writes_done, reads_done, rejects);
    $display("Half periods 0 to 3 and 65535, with a long result hold-off and a gap-free stretch.");
    if (errors == 0 && status_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
